/* hw/rtl/cprt_pkg.sv */
// Package for the camera point rigid transform: coordinate and coefficient
// widths, register indexes, reset values and the per-row configuration struct.
// No dependencies.
`default_nettype none

package cprt_pkg;

	// Coordinate format: signed Q7.16 at the default width
	localparam int COORD_WIDTH = 24;
	localparam int COEF_WIDTH  = 16;
	localparam int ROW_WIDTH   = 3 * COEF_WIDTH;
	localparam int FRAC_SHIFT  = 14;

	// Product, accumulator and post-shift widths
	localparam int PROD_WIDTH  = COORD_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH   = COORD_WIDTH + COEF_WIDTH + 2;
	localparam int SHR_WIDTH   = ACC_WIDTH - FRAC_SHIFT;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// Configuration port
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = ROW_WIDTH;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_ROW_X  = 3'd0,
		REG_ROW_Y  = 3'd1,
		REG_ROW_Z  = 3'd2,
		REG_OFFS_X = 3'd3,
		REG_OFFS_Y = 3'd4,
		REG_OFFS_Z = 3'd5
	} cfg_reg_t;

	// Reset values: identity rotation, head height 1.49 m on z
	localparam logic [ROW_WIDTH-1:0] ROW_X_RST = ROW_WIDTH'(48'h0000_0000_4000);
	localparam logic [ROW_WIDTH-1:0] ROW_Y_RST = ROW_WIDTH'(48'h0000_4000_0000);
	localparam logic [ROW_WIDTH-1:0] ROW_Z_RST = ROW_WIDTH'(48'h4000_0000_0000);
	localparam logic signed [COORD_WIDTH-1:0] OFFS_X_RST = '0;
	localparam logic signed [COORD_WIDTH-1:0] OFFS_Y_RST = '0;
	localparam logic signed [COORD_WIDTH-1:0] OFFS_Z_RST = COORD_WIDTH'(97649);

	// One output row: three packed coefficients and its translation
	typedef struct packed {
		logic [ROW_WIDTH-1:0]          coeffs;
		logic signed [COORD_WIDTH-1:0] offset;
	} row_cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/cprt_point_if.sv */
// Valid/ready channel carrying one camera point (three signed coordinates).
// Depends on cprt_pkg.
`default_nettype none

interface cprt_point_if;
	import cprt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] cam_a;
	logic signed [COORD_WIDTH-1:0] cam_b;
	logic signed [COORD_WIDTH-1:0] cam_c;

	modport source (output valid, output cam_a, output cam_b, output cam_c, input ready);
	modport sink   (input valid, input cam_a, input cam_b, input cam_c, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cprt_world_if.sv */
// Valid/ready channel carrying one transformed world point and its clip flag.
// Depends on cprt_pkg.
`default_nettype none

interface cprt_world_if;
	import cprt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] world_x;
	logic signed [COORD_WIDTH-1:0] world_y;
	logic signed [COORD_WIDTH-1:0] world_z;
	logic                          clipped;

	modport source (output valid, output world_x, output world_y, output world_z,
		output clipped, input ready);
	modport sink   (input valid, input world_x, input world_y, input world_z,
		input clipped, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cprt_cfg_regs.sv */
// Configuration register file: three coefficient rows and three offsets,
// written through a plain write port. Depends on cprt_pkg.
`default_nettype none

module cprt_cfg_regs (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [cprt_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  wire logic [cprt_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
	output cprt_pkg::row_cfg_t                         row_x,
	output cprt_pkg::row_cfg_t                         row_y,
	output cprt_pkg::row_cfg_t                         row_z
);
	import cprt_pkg::*;

	logic [ROW_WIDTH-1:0]          row_x_q, row_y_q, row_z_q;
	logic signed [COORD_WIDTH-1:0] offs_x_q, offs_y_q, offs_z_q;
	logic signed [COORD_WIDTH-1:0] wdata_coord;

	assign wdata_coord = cfg_wdata[COORD_WIDTH-1:0];

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q  <= ROW_X_RST;
			row_y_q  <= ROW_Y_RST;
			row_z_q  <= ROW_Z_RST;
			offs_x_q <= OFFS_X_RST;
			offs_y_q <= OFFS_Y_RST;
			offs_z_q <= OFFS_Z_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_X:  row_x_q  <= cfg_wdata[ROW_WIDTH-1:0];
				REG_ROW_Y:  row_y_q  <= cfg_wdata[ROW_WIDTH-1:0];
				REG_ROW_Z:  row_z_q  <= cfg_wdata[ROW_WIDTH-1:0];
				REG_OFFS_X: offs_x_q <= wdata_coord;
				REG_OFFS_Y: offs_y_q <= wdata_coord;
				REG_OFFS_Z: offs_z_q <= wdata_coord;
				default: ;
			endcase
		end
	end

	assign row_x = '{coeffs: row_x_q, offset: offs_x_q};
	assign row_y = '{coeffs: row_y_q, offset: offs_y_q};
	assign row_z = '{coeffs: row_z_q, offset: offs_z_q};

endmodule

`default_nettype wire

/* hw/rtl/cprt_row.sv */
// One output row: dot product of the remapped point with three Q1.14
// coefficients, plus offset, round half up, shift and saturate. Depends on cprt_pkg.
`default_nettype none

module cprt_row (
	input  wire cprt_pkg::row_cfg_t                    cfg,
	input  wire logic signed [cprt_pkg::COORD_WIDTH-1:0] x,
	input  wire logic signed [cprt_pkg::COORD_WIDTH-1:0] y,
	input  wire logic signed [cprt_pkg::COORD_WIDTH-1:0] z,
	output logic signed [cprt_pkg::COORD_WIDTH-1:0]      res,
	output logic                                         clip
);
	import cprt_pkg::*;

	localparam logic signed [ACC_WIDTH-1:0] HALF_LSB = ACC_WIDTH'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [SHR_WIDTH-1:0] SAT_HI   = SHR_WIDTH'(COORD_MAX);
	localparam logic signed [SHR_WIDTH-1:0] SAT_LO   = SHR_WIDTH'(COORD_MIN);

	logic signed [COEF_WIDTH-1:0] c0, c1, c2;
	logic signed [PROD_WIDTH-1:0] p0, p1, p2;
	logic signed [ACC_WIDTH-1:0]  acc;
	logic signed [ACC_WIDTH-1:0]  acc_shr;
	logic signed [SHR_WIDTH-1:0]  sh;

	assign c0 = cfg.coeffs[COEF_WIDTH-1:0];
	assign c1 = cfg.coeffs[2*COEF_WIDTH-1:COEF_WIDTH];
	assign c2 = cfg.coeffs[3*COEF_WIDTH-1:2*COEF_WIDTH];

	// Three parallel products, Q.30
	assign p0 = PROD_WIDTH'(x) * PROD_WIDTH'(c0);
	assign p1 = PROD_WIDTH'(y) * PROD_WIDTH'(c1);
	assign p2 = PROD_WIDTH'(z) * PROD_WIDTH'(c2);

	// Exact sum with offset aligned to Q.30, plus rounding half
	assign acc = ACC_WIDTH'(p0) + ACC_WIDTH'(p1) + ACC_WIDTH'(p2)
		+ (ACC_WIDTH'(cfg.offset) <<< FRAC_SHIFT) + HALF_LSB;

	// Floor shift back to Q.16
	assign acc_shr = acc >>> FRAC_SHIFT;
	assign sh      = acc_shr[SHR_WIDTH-1:0];

	// Saturate to the coordinate range
	always_comb begin
		if (sh > SAT_HI) begin
			res  = COORD_MAX;
			clip = 1'b1;
		end else if (sh < SAT_LO) begin
			res  = COORD_MIN;
			clip = 1'b1;
		end else begin
			res  = sh[COORD_WIDTH-1:0];
			clip = 1'b0;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/camera_point_rigid_transform.sv */
// Top level of the camera point rigid transform: input register, axis remap,
// three row units and the result register. Depends on cprt_pkg, cprt_point_if,
// cprt_world_if, cprt_cfg_regs and cprt_row.
//
//   channel   direction  payload                              handshake
//   pt_in     in         cam_a, cam_b, cam_c                  valid / ready
//   pt_out    out        world_x, world_y, world_z, clipped   valid / ready
//   cfg       in         cfg_index, cfg_wdata                 cfg_we, no wait
//
// One transaction per cycle while pt_out is not stalled; an accepted input is held
// in the input register, then loaded into the result register after the multiply/add.
// Reset clears both valid flags and loads identity rotation, zero x/y offset
// and 1.49 m z offset. A stalled output holds its result; the input register
// keeps accepting as long as the result register is free or being drained.
`default_nettype none

module camera_point_rigid_transform (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	cprt_point_if.sink                               pt_in,
	cprt_world_if.source                             pt_out,
	input  wire logic                                cfg_we,
	input  wire logic [cprt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  wire logic [cprt_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);
	import cprt_pkg::*;

	row_cfg_t row_x, row_y, row_z;

	logic                          valid_s1;
	logic signed [COORD_WIDTH-1:0] a_s1, b_s1, c_s1;
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] wx_q, wy_q, wz_q;
	logic                          clip_q;

	logic                          out_free;
	logic                          adv_s1;
	logic                          is_zero;
	logic                          neg_clip;
	logic signed [COORD_WIDTH-1:0] rx, ry, rz;
	logic signed [COORD_WIDTH-1:0] res_x, res_y, res_z;
	logic                          clip_x, clip_y, clip_z;

	cprt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.row_x     (row_x),
		.row_y     (row_y),
		.row_z     (row_z)
	);

	// Handshake: stage 1 moves on when the result register can take it
	assign out_free     = !out_valid_q || pt_out.ready;
	assign adv_s1       = valid_s1 && out_free;
	assign pt_in.ready  = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pt_in.ready) begin
			valid_s1 <= pt_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pt_in.valid && pt_in.ready) begin
			a_s1 <= pt_in.cam_a;
			b_s1 <= pt_in.cam_b;
			c_s1 <= pt_in.cam_c;
		end
	end

	// Axis remap: x = ch2, y = -ch0 (saturating), z = ch1
	assign is_zero  = (a_s1 == '0) && (b_s1 == '0) && (c_s1 == '0);
	assign neg_clip = (a_s1 == COORD_MIN);
	assign rx       = c_s1;
	assign ry       = neg_clip ? COORD_MAX : -a_s1;
	assign rz       = b_s1;

	cprt_row u_row_x (.cfg(row_x), .x(rx), .y(ry), .z(rz), .res(res_x), .clip(clip_x));
	cprt_row u_row_y (.cfg(row_y), .x(rx), .y(ry), .z(rz), .res(res_y), .clip(clip_y));
	cprt_row u_row_z (.cfg(row_z), .x(rx), .y(ry), .z(rz), .res(res_z), .clip(clip_z));

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Zero point bypasses the translation
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (is_zero) begin
				wx_q   <= '0;
				wy_q   <= '0;
				wz_q   <= '0;
				clip_q <= 1'b0;
			end else begin
				wx_q   <= res_x;
				wy_q   <= res_y;
				wz_q   <= res_z;
				clip_q <= neg_clip || clip_x || clip_y || clip_z;
			end
		end
	end

	assign pt_out.valid   = out_valid_q;
	assign pt_out.world_x = wx_q;
	assign pt_out.world_y = wy_q;
	assign pt_out.world_z = wz_q;
	assign pt_out.clipped = clip_q;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for camera_point_rigid_transform: drives camera points and
// register writes, predicts each world point and compares it with the block's result.
// Depends on cprt_pkg, cprt_point_if, cprt_world_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
	import cprt_pkg::*;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [ROW_WIDTH-1:0] row_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   clipped;
	} world_pt_t;

	// Indexes with no register behind them
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int BLOCK_ITEMS  = 50;
	localparam int BLOCK_COUNT  = 15;

	// Holds a copy of the configuration and the queue of predicted world points
	class transform_scoreboard;
		row_t      rows[3];
		coord_t    offs[3];
		world_pt_t expected_world[$];
		int        failures;

		function new();
			rows[0] = ROW_X_RST;
			rows[1] = ROW_Y_RST;
			rows[2] = ROW_Z_RST;
			offs[0] = OFFS_X_RST;
			offs[1] = OFFS_Y_RST;
			offs[2] = OFFS_Z_RST;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx,
				logic [CFG_DATA_WIDTH-1:0] data);
			case (idx)
				REG_ROW_X:  rows[0] = data[ROW_WIDTH-1:0];
				REG_ROW_Y:  rows[1] = data[ROW_WIDTH-1:0];
				REG_ROW_Z:  rows[2] = data[ROW_WIDTH-1:0];
				REG_OFFS_X: offs[0] = data[COORD_WIDTH-1:0];
				REG_OFFS_Y: offs[1] = data[COORD_WIDTH-1:0];
				REG_OFFS_Z: offs[2] = data[COORD_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		// Dot product of one row with the remapped point, plus offset, rounded and clamped
		function coord_t row_sum(row_t row, coord_t off, longint px, longint py,
				longint pz, output bit sat);
			longint acc;
			longint q;
			acc = longint'($signed(row[COEF_WIDTH-1:0])) * px
				+ longint'($signed(row[2*COEF_WIDTH-1:COEF_WIDTH])) * py
				+ longint'($signed(row[3*COEF_WIDTH-1:2*COEF_WIDTH])) * pz;
			acc += longint'(off) * (longint'(1) <<< FRAC_SHIFT);
			acc += longint'(1) <<< (FRAC_SHIFT - 1);
			q = acc >>> FRAC_SHIFT;
			sat = 1'b0;
			if (q > longint'(COORD_MAX)) begin
				q = longint'(COORD_MAX);
				sat = 1'b1;
			end else if (q < longint'(COORD_MIN)) begin
				q = longint'(COORD_MIN);
				sat = 1'b1;
			end
			return coord_t'(q);
		endfunction

		function void note_point(coord_t a, coord_t b, coord_t c);
			world_pt_t w;
			longint    px;
			longint    py;
			longint    pz;
			bit        s0;
			bit        s1;
			bit        s2;
			bit        neg_sat;
			w = '0;
			if (a != 0 || b != 0 || c != 0) begin
				// Axis remap: x from depth, y from negated channel 0, z from channel 1
				px = longint'(c);
				py = -longint'(a);
				pz = longint'(b);
				neg_sat = 1'b0;
				if (py > longint'(COORD_MAX)) begin
					py = longint'(COORD_MAX);
					neg_sat = 1'b1;
				end
				w.x = row_sum(rows[0], offs[0], px, py, pz, s0);
				w.y = row_sum(rows[1], offs[1], px, py, pz, s1);
				w.z = row_sum(rows[2], offs[2], px, py, pz, s2);
				w.clipped = neg_sat | s0 | s1 | s2;
			end
			expected_world.push_back(w);
		endfunction

		function void check_world(world_pt_t got);
			world_pt_t want;
			if (expected_world.size() == 0) begin
				failures++;
				$display("%0t: world point with no transaction pending: %0d %0d %0d clip %0b",
					$time, got.x, got.y, got.z, got.clipped);
				return;
			end
			want = expected_world.pop_front();
			if (want !== got) begin
				failures++;
				$display("%0t: mismatch, expected %0d %0d %0d clip %0b, actual %0d %0d %0d clip %0b",
					$time, want.x, want.y, want.z, want.clipped,
					got.x, got.y, got.z, got.clipped);
			end
		endfunction

		function int pending();
			return expected_world.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index;
	logic [CFG_DATA_WIDTH-1:0] cfg_wdata;

	int src_idle_pct;
	int sink_idle_pct;
	int stall_cycles;

	cprt_point_if pt_in_if();
	cprt_world_if pt_out_if();

	transform_scoreboard sb = new();

	camera_point_rigid_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_in     (pt_in_if),
		.pt_out    (pt_out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Receiver back-pressure
	always @(negedge clk) begin
		pt_out_if.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	// Monitor: register writes, accepted points, results, stall count
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_wdata);
			if (pt_in_if.valid && pt_in_if.ready)
				sb.note_point(pt_in_if.cam_a, pt_in_if.cam_b, pt_in_if.cam_c);
			if (pt_out_if.valid && pt_out_if.ready)
				sb.check_world('{pt_out_if.world_x, pt_out_if.world_y,
					pt_out_if.world_z, pt_out_if.clipped});
			if (cfg_we || (pt_in_if.valid && pt_in_if.ready)
					|| (pt_out_if.valid && pt_out_if.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic send_point(input coord_t a, input coord_t b, input coord_t c);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			pt_in_if.valid <= 1'b0;
			@(negedge clk);
		end
		pt_in_if.valid <= 1'b1;
		pt_in_if.cam_a <= a;
		pt_in_if.cam_b <= b;
		pt_in_if.cam_c <= c;
		@(posedge clk);
		while (!pt_in_if.ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every transaction has come back
	task automatic drain();
		@(negedge clk);
		pt_in_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Write all six registers; offsets carry junk above the coordinate width
	task automatic load_config(input row_t rx, input row_t ry, input row_t rz,
			input coord_t ox, input coord_t oy, input coord_t oz);
		logic [CFG_DATA_WIDTH-COORD_WIDTH-1:0] junk;
		junk = (CFG_DATA_WIDTH-COORD_WIDTH)'({$urandom(), $urandom()});
		write_reg(REG_ROW_X, rx);
		write_reg(REG_ROW_Y, ry);
		write_reg(REG_ROW_Z, rz);
		write_reg(REG_OFFS_X, {junk, ox});
		write_reg(REG_OFFS_Y, {~junk, oy});
		write_reg(REG_OFFS_Z, {junk, oz});
		// Unused indexes must not disturb anything
		write_reg(REG_SPARE_LO, CFG_DATA_WIDTH'({$urandom(), $urandom()}));
		write_reg(REG_SPARE_HI, CFG_DATA_WIDTH'({$urandom(), $urandom()}));
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return '0;
			3, 4: return coord_t'($urandom_range(8191)) - coord_t'(4096);
			default: return coord_t'($urandom());
		endcase
	endfunction

	function automatic logic [COEF_WIDTH-1:0] rand_rot_coef();
		return COEF_WIDTH'(int'($urandom_range(32768)) - 16384);
	endfunction

	function automatic row_t rand_rot_row();
		return {rand_rot_coef(), rand_rot_coef(), rand_rot_coef()};
	endfunction

	task automatic random_config(input int kind);
		row_t r[3];
		case (kind)
			0: begin
				for (int i = 0; i < 3; i++)
					r[i] = row_t'({$urandom(), $urandom()});
				load_config(r[0], r[1], r[2], coord_t'($urandom()), coord_t'($urandom()),
					coord_t'($urandom()));
			end
			1: begin
				load_config(rand_rot_row(), rand_rot_row(), rand_rot_row(),
					coord_t'($urandom_range(262143)) - coord_t'(131072),
					coord_t'($urandom_range(262143)) - coord_t'(131072),
					coord_t'($urandom_range(262143)));
			end
			2: load_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
				COORD_MAX, COORD_MAX, COORD_MAX);
			3: load_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
				COORD_MIN, COORD_MIN, COORD_MIN);
			default: load_config(ROW_X_RST, ROW_Y_RST, ROW_Z_RST,
				OFFS_X_RST, OFFS_Y_RST, OFFS_Z_RST);
		endcase
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pt_in_if.valid = 1'b0;
		pt_in_if.cam_a = '0;
		pt_in_if.cam_b = '0;
		pt_in_if.cam_c = '0;
		pt_out_if.ready = 1'b0;
		stall_cycles = 0;
		src_idle_pct = 12;
		sink_idle_pct = 85;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: zero point, negation of the most negative channel 0, extremes
		send_point('0, '0, '0);
		send_point(COORD_MIN, '0, '0);
		send_point(COORD_MAX, COORD_MIN, COORD_MAX);
		send_point(COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(coord_t'(1), coord_t'(-1), coord_t'(1));
		send_point('0, '0, coord_t'(1));
		drain();

		// Largest coefficients and offsets: positive overflow
		load_config({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
			COORD_MAX, COORD_MAX, COORD_MAX);
		send_point(COORD_MIN, COORD_MAX, COORD_MAX);
		send_point('0, '0, '0);
		send_point(coord_t'(-1), '0, '0);
		drain();

		// Most negative coefficients and offsets
		load_config({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
			COORD_MIN, COORD_MIN, COORD_MIN);
		send_point(COORD_MIN, COORD_MAX, COORD_MAX);
		send_point(COORD_MAX, COORD_MIN, COORD_MIN);
		send_point('0, '0, '0);
		drain();

		// Rounding ties: half an LSB rounds up on both signs
		load_config(48'h0000_0000_0001, 48'h0000_0001_0000, 48'hFFFF_0000_0000,
			'0, '0, '0);
		send_point('0, '0, coord_t'(8192));
		send_point('0, '0, coord_t'(-8192));
		send_point(coord_t'(8192), '0, '0);
		send_point('0, coord_t'(-8192), coord_t'(24576));
		drain();

		// Random blocks, each under a fresh configuration
		for (int blk = 0; blk < BLOCK_COUNT; blk++) begin
			if (blk < 5) begin
				src_idle_pct = 12;
				sink_idle_pct = 85;
			end else if (blk < 10) begin
				src_idle_pct = 85;
				sink_idle_pct = 12;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			random_config(blk % 5);
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				if ($urandom_range(24) == 0)
					send_point('0, '0, '0);
				else
					send_point(rand_coord(), rand_coord(), rand_coord());
			end
			drain();
		end

		if (sb.failures == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/cprt_pkg.sv
hw/rtl/cprt_point_if.sv
hw/rtl/cprt_world_if.sv
hw/rtl/cprt_cfg_regs.sv
hw/rtl/cprt_row.sv
hw/rtl/camera_point_rigid_transform.sv
test/testbench.sv
